@@ rtl/rpv_pkg.sv @@
// ----------------------------------------------------------------------------
// rpv_pkg
// Shared constants and types for the relative path validator.
// ----------------------------------------------------------------------------
package rpv_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned SIZE_W = 13;
    localparam int unsigned COMP_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CTRL_BOUND     = 8'h20;
    localparam logic [CHAR_W-1:0] SLASH_CHAR     = 8'h2F;
    localparam logic [CHAR_W-1:0] DOT_CHAR       = 8'h2E;
    localparam logic [CHAR_W-1:0] BACKSLASH_CHAR = 8'h5C;

    localparam logic [COMP_W-1:0] COMP_EMPTY = 2'd0;
    localparam logic [COMP_W-1:0] COMP_ONE   = 2'd1;
    localparam logic [COMP_W-1:0] COMP_TWO   = 2'd2;
    localparam logic [COMP_W-1:0] COMP_MANY  = 2'd3;

    typedef struct packed {
        logic              done;
        logic              ok;
        logic [SIZE_W-1:0] size;
    } rpv_verdict_t;

endpackage

@@ rtl/rpv_check.sv @@
// ----------------------------------------------------------------------------
// rpv_check
// Per-path state and verdict logic; consumes one word per enabled cycle.
// ----------------------------------------------------------------------------
module rpv_check
    import rpv_pkg::*;
#(
    parameter int unsigned PATH_LIMIT = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CHAR_W-1:0] ch,
    output rpv_verdict_t      verdict
);

    localparam int unsigned CNT_W = $clog2(PATH_LIMIT + 1);
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(PATH_LIMIT);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [COMP_W-1:0] comp_reg, comp_next;
    logic              first_dot_reg, first_dot_next;
    logic              second_dot_reg, second_dot_next;
    logic              rejected_reg, rejected_next;
    logic              comp_bad;
    logic              is_dot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            comp_reg       <= COMP_EMPTY;
            first_dot_reg  <= 1'b0;
            second_dot_reg <= 1'b0;
            rejected_reg   <= 1'b0;
        end
        else if (step)
        begin
            count_reg      <= count_next;
            comp_reg       <= comp_next;
            first_dot_reg  <= first_dot_next;
            second_dot_reg <= second_dot_next;
            rejected_reg   <= rejected_next;
        end
    end

    always_comb
    begin
        comp_bad = (comp_reg == COMP_EMPTY)
                || (comp_reg == COMP_ONE && first_dot_reg)
                || (comp_reg == COMP_TWO && first_dot_reg && second_dot_reg);
        is_dot = (ch == DOT_CHAR);

        count_next      = count_reg;
        comp_next       = comp_reg;
        first_dot_next  = first_dot_reg;
        second_dot_next = second_dot_reg;
        rejected_next   = rejected_reg;

        verdict.done = step && (ch == CHAR_NUL);
        verdict.ok   = !rejected_reg && (count_reg != '0) && !comp_bad;
        verdict.size = verdict.ok ? SIZE_W'(count_reg) : '0;

        if (ch == CHAR_NUL)
        begin
            count_next      = '0;
            comp_next       = COMP_EMPTY;
            first_dot_next  = 1'b0;
            second_dot_next = 1'b0;
            rejected_next   = 1'b0;
        end
        else
        begin
            if (!rejected_reg)
            begin
                if (count_reg >= LIMIT_C)
                begin
                    rejected_next = 1'b1;
                end
                else if (ch < CTRL_BOUND || ch == BACKSLASH_CHAR)
                begin
                    rejected_next = 1'b1;
                end
                else if (ch == SLASH_CHAR)
                begin
                    if (count_reg == '0 || comp_bad)
                    begin
                        rejected_next = 1'b1;
                    end
                    else
                    begin
                        comp_next       = COMP_EMPTY;
                        first_dot_next  = 1'b0;
                        second_dot_next = 1'b0;
                    end
                end
                else
                begin
                    case (comp_reg)
                        COMP_EMPTY: first_dot_next  = is_dot;
                        COMP_ONE:   second_dot_next = is_dot;
                        default:    ;
                    endcase
                    if (comp_reg != COMP_MANY)
                    begin
                        comp_next = comp_reg + COMP_W'(1);
                    end
                end
            end
            if (count_reg < LIMIT_C)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/relative_path_validator.sv @@
// ----------------------------------------------------------------------------
// relative_path_validator
// Checks a zero-terminated byte stream for a well-formed relative path.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (char_valid / char_stall / path_char) carries one path
//   byte per word; a zero byte ends the path. Each terminator yields one
//   word on the result channel (result_valid / result_stall / path_ok /
//   path_size); other bytes yield nothing. path_size is 0 on rejection.
//   Throughput is one byte per cycle while char_stall is low. Each byte
//   is registered on entry and then checked against the per-path state;
//   a terminator's verdict is registered in the result register, which
//   drives result_valid. When the result register is full and stalled,
//   a terminator waits in the entry register and char_stall rises;
//   ordinary bytes keep flowing. Reset clears all path state and both
//   valid flags; char_stall is low out of reset, so the block accepts
//   bytes once reset is released.
// ----------------------------------------------------------------------------
module relative_path_validator
    import rpv_pkg::*;
#(
    parameter int unsigned PATH_LIMIT = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  logic [CHAR_W-1:0] path_char,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              path_ok,
    output logic [SIZE_W-1:0] path_size
);

    logic              hold_valid_reg;
    logic [CHAR_W-1:0] hold_char_reg;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [SIZE_W-1:0] out_size_reg;
    logic              out_free;
    logic              advance;
    rpv_verdict_t      verdict;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = hold_valid_reg && ((hold_char_reg != CHAR_NUL) || out_free);
    assign char_stall = hold_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            hold_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
        begin
            hold_char_reg <= path_char;
        end
    end

    rpv_check #(
        .PATH_LIMIT (PATH_LIMIT)
    ) u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .ch      (hold_char_reg),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (verdict.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (verdict.done)
        begin
            out_ok_reg   <= verdict.ok;
            out_size_reg <= verdict.size;
        end
    end

    assign result_valid = out_valid_reg;
    assign path_ok      = out_ok_reg;
    assign path_size    = out_size_reg;

`ifndef SYNTH
    a_reject_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_size_reg == '0))
        else $error("rejected path reports nonzero size");

    a_stall_only_terminator: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> (hold_valid_reg && hold_char_reg == CHAR_NUL && !out_free))
        else $error("input stalled without a blocked terminator");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |=> (out_valid_reg && $stable(out_ok_reg)
            && $stable(out_size_reg)))
        else $error("pending result overwritten");
`endif

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for relative_path_validator: streams path bytes through the
// input channel and tracks each path in an in-bench validity tracker. The
// expected verdict for every terminator is compared with the result channel.
// The stimulus covers short directed paths, random well-formed paths with
// injected faults and noise, the length limit, and long result back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import rpv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PATH_LIMIT  = 4096;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef logic [CHAR_W-1:0] char_t;

    typedef struct packed {
        logic              ok;
        logic [SIZE_W-1:0] size;
    } verdict_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_LEAD_SLASH,
        FAULT_LEAD_BACKSLASH,
        FAULT_CTRL,
        FAULT_BACKSLASH,
        FAULT_EMPTY_COMP,
        FAULT_DOT,
        FAULT_DOTDOT,
        FAULT_TRAILING,
        FAULT_EMPTY_PATH
    } path_fault_e;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              char_valid   = 1'b0;
    logic              char_stall;
    char_t             path_char    = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              path_ok;
    logic [SIZE_W-1:0] path_size;

    // tracker state for the path in flight
    logic [SIZE_W-1:0] path_len;
    logic [COMP_W-1:0] comp_len;
    logic              lead_dot;
    logic              second_dot;
    logic              path_bad;

    verdict_t expected_verdicts[$];
    char_t    path_buf[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned sink_hold      = 0;
    int unsigned error_count    = 0;
    int unsigned chars_sent     = 0;
    int unsigned verdicts_seen  = 0;
    int unsigned verdicts_ok    = 0;
    int unsigned input_stalls   = 0;
    int unsigned cycle_count    = 0;

    relative_path_validator #(
        .PATH_LIMIT(PATH_LIMIT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .path_char   (path_char),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .path_ok     (path_ok),
        .path_size   (path_size)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (char_valid && char_stall)
            input_stalls++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, expected_verdicts.size());
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge clk)
    begin
        if (sink_hold != 0)
        begin
            sink_hold = sink_hold - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s at verdict %0d: got %0d, expected %0d",
                 what, verdicts_seen, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch("unexpected word", path_ok, 0);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (want.ok)
                    verdicts_ok++;
                if (path_ok !== want.ok)
                    report_mismatch("path_ok", path_ok, want.ok);
                if (path_size !== want.size)
                    report_mismatch("path_size", path_size, want.size);
            end
        end
    end

    function automatic logic comp_invalid();
        return (comp_len == COMP_EMPTY)
            || (comp_len == COMP_ONE && lead_dot)
            || (comp_len == COMP_TWO && lead_dot && second_dot);
    endfunction

    task automatic clear_path();
        path_len   = '0;
        comp_len   = COMP_EMPTY;
        lead_dot   = 1'b0;
        second_dot = 1'b0;
        path_bad   = 1'b0;
    endtask

    task automatic predict_verdict(input char_t c);
        verdict_t v;
        if (c == CHAR_NUL)
        begin
            v.ok   = !path_bad && path_len != 0 && !comp_invalid();
            v.size = v.ok ? path_len : '0;
            expected_verdicts.push_back(v);
            clear_path();
        end
        else
        begin
            if (!path_bad)
            begin
                if (path_len >= PATH_LIMIT)
                    path_bad = 1'b1;
                else if (c < CTRL_BOUND || c == BACKSLASH_CHAR)
                    path_bad = 1'b1;
                else if (c == SLASH_CHAR)
                begin
                    if (path_len == 0 || comp_invalid())
                        path_bad = 1'b1;
                    else
                    begin
                        comp_len   = COMP_EMPTY;
                        lead_dot   = 1'b0;
                        second_dot = 1'b0;
                    end
                end
                else
                begin
                    if (comp_len == COMP_EMPTY)
                        lead_dot = (c == DOT_CHAR);
                    else if (comp_len == COMP_ONE)
                        second_dot = (c == DOT_CHAR);
                    if (comp_len != COMP_MANY)
                        comp_len = comp_len + 1'b1;
                end
            end
            if (path_len < PATH_LIMIT)
                path_len = path_len + 1'b1;
        end
    endtask

    task automatic send_char(input char_t c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            char_valid <= 1'b0;
            path_char  <= char_t'($urandom);
        end
        @(negedge clk);
        char_valid <= 1'b1;
        path_char  <= c;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        predict_verdict(c);
        chars_sent++;
    endtask

    task automatic send_path_buf();
        foreach (path_buf[i])
            send_char(path_buf[i]);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        char_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic char_t rand_name_char();
        char_t c;
        if ($urandom_range(99) < 25)
            return DOT_CHAR;
        do
            c = char_t'($urandom_range(CTRL_BOUND, 8'hFF));
        while (c == SLASH_CHAR || c == BACKSLASH_CHAR);
        return c;
    endfunction

    task automatic build_path(input path_fault_e fault);
        int n_comp;
        int bad_comp;
        int pos;
        path_buf.delete();
        if (fault == FAULT_EMPTY_PATH)
        begin
            path_buf.push_back(CHAR_NUL);
            return;
        end
        n_comp   = $urandom_range(1, 4);
        bad_comp = $urandom_range(0, n_comp - 1);
        for (int k = 0; k < n_comp; k++)
        begin
            if (k != 0)
                path_buf.push_back(SLASH_CHAR);
            if (k == bad_comp && fault == FAULT_EMPTY_COMP)
                ;
            else if (k == bad_comp && fault == FAULT_DOT)
                path_buf.push_back(DOT_CHAR);
            else if (k == bad_comp && fault == FAULT_DOTDOT)
            begin
                path_buf.push_back(DOT_CHAR);
                path_buf.push_back(DOT_CHAR);
            end
            else
                repeat ($urandom_range(1, 5))
                    path_buf.push_back(rand_name_char());
        end
        pos = $urandom_range(0, path_buf.size());
        case (fault)
            FAULT_LEAD_SLASH:     path_buf.push_front(SLASH_CHAR);
            FAULT_LEAD_BACKSLASH: path_buf.push_front(BACKSLASH_CHAR);
            FAULT_CTRL:           path_buf.insert(pos, char_t'($urandom_range(1, CTRL_BOUND - 1)));
            FAULT_BACKSLASH:      path_buf.insert(pos, BACKSLASH_CHAR);
            FAULT_TRAILING:       path_buf.push_back(SLASH_CHAR);
            default:              ;
        endcase
        path_buf.push_back(CHAR_NUL);
    endtask

    task automatic test_directed();
        path_buf = '{
            CHAR_NUL,
            SLASH_CHAR, "a", CHAR_NUL,
            BACKSLASH_CHAR, CHAR_NUL,
            "a", 8'h1F, CHAR_NUL,
            "a", SLASH_CHAR, CHAR_NUL,
            "a", SLASH_CHAR, SLASH_CHAR, "b", CHAR_NUL,
            DOT_CHAR, CHAR_NUL,
            DOT_CHAR, DOT_CHAR, SLASH_CHAR, "b", CHAR_NUL,
            DOT_CHAR, DOT_CHAR, 8'hFF, SLASH_CHAR, 8'h20, CHAR_NUL
        };
        send_path_buf();
    endtask

    task automatic test_random_paths(input int unsigned n_chars);
        int unsigned target;
        int unsigned pick;
        target = chars_sent + n_chars;
        while (chars_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                repeat ($urandom_range(1, 8))
                    send_char(($urandom_range(99) < 20) ? CHAR_NUL : char_t'($urandom));
            end
            else
            begin
                if (pick < 55)
                    build_path(FAULT_NONE);
                else
                    build_path(path_fault_e'($urandom_range(FAULT_LEAD_SLASH,
                                                            FAULT_EMPTY_PATH)));
                send_path_buf();
            end
        end
        send_char(CHAR_NUL);
    endtask

    task automatic test_backpressure();
        sink_hold = 60;
        repeat (25)
        begin
            send_char("a");
            send_char(CHAR_NUL);
        end
    endtask

    task automatic test_length_limit();
        // exactly at the limit, one over, and a few over with counter saturated
        repeat (PATH_LIMIT)
            send_char("x");
        send_char(CHAR_NUL);
        repeat (PATH_LIMIT + 1)
            send_char("x");
        send_char(CHAR_NUL);
        repeat (PATH_LIMIT + 3)
            send_char(DOT_CHAR);
        send_char(CHAR_NUL);
    endtask

    initial
    begin
        clear_path();
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct   = 37;
        sink_stall_pct = 67;
        test_directed();
        test_random_paths(215);
        wait_drain();

        src_idle_pct   = 67;
        sink_stall_pct = 37;
        test_random_paths(215);
        test_backpressure();
        wait_drain();

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_paths(215);
        test_length_limit();
        wait_drain();

        repeat (8)
            @(posedge clk);
        $display("Sent %0d path bytes; checked %0d verdicts (%0d valid paths)",
                 chars_sent, verdicts_seen, verdicts_ok);
        $display("Covered faults, length limit, and %0d cycles of input stall",
                 input_stalls);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
